// File: rtl/sblb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblb_pkg
// Command and status codes and fixed field widths of the slotted list bank.
// ----------------------------------------------------------------------------
package sblb_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 5;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CREATE          = 4'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND          = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DROP_LAST       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE          = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RESIZE          = 4'd4;
  localparam logic [CMD_W-1:0] CMD_READ            = 4'd5;
  localparam logic [CMD_W-1:0] CMD_READ_SORTED     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT           = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_ALL        = 4'd8;
  localparam logic [CMD_W-1:0] CMD_READ_ALL_SORTED = 4'd9;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS       = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NO_LIST      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FULL         = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BAD_NEW_SIZE = 4'd9;
  localparam logic [STATUS_W-1:0] ST_ALL_EMPTY    = 4'd10;

  // Outcome of one key comparison
  typedef struct packed {
    logic above_prev;
    logic below_best;
    logic match;
  } key_cmp_t;

endpackage : sblb_pkg
`default_nettype wire

// File: rtl/sblb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblb_store
// Word store of the list bank: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sblb_store
  import sblb_pkg::*;
#(
  parameter int AW = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**AW];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : sblb_store
`default_nettype wire

// File: rtl/sblb_key_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblb_key_unit
// Shared compare unit: orders a candidate word against the last emitted key
// and the best key so far, and tests it for equality with the search value.
// ----------------------------------------------------------------------------
module sblb_key_unit
  import sblb_pkg::*;
#(
  parameter int AW = 6
) (
  input  wire logic              sorted,
  input  wire logic [DATA_W-1:0] cand_value,
  input  wire logic [AW-1:0]     cand_addr,
  input  wire logic [DATA_W-1:0] prev_value,
  input  wire logic [AW-1:0]     prev_addr,
  input  wire logic [DATA_W-1:0] best_value,
  input  wire logic [AW-1:0]     best_addr,
  input  wire logic [DATA_W-1:0] ref_value,
  output key_cmp_t               cmp
);

  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W+AW-1:0] cand_key;
  logic [DATA_W+AW-1:0] prev_key;
  logic [DATA_W+AW-1:0] best_key;

  // Build keys: biased value then address when sorted, address alone otherwise
  always_comb begin
    if (sorted) begin
      cand_key = {cand_value ^ SIGN_FLIP, cand_addr};
      prev_key = {prev_value ^ SIGN_FLIP, prev_addr};
      best_key = {best_value ^ SIGN_FLIP, best_addr};
    end else begin
      cand_key = {{DATA_W{1'b0}}, cand_addr};
      prev_key = {{DATA_W{1'b0}}, prev_addr};
      best_key = {{DATA_W{1'b0}}, best_addr};
    end
  end

  assign cmp.above_prev = cand_key > prev_key;
  assign cmp.below_best = cand_key < best_key;
  assign cmp.match      = cand_value == ref_value;

endmodule : sblb_key_unit
`default_nettype wire

// File: rtl/slotted_bounded_list_bank_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slotted_bounded_list_bank_unit
// Bank of numbered slots, each holding a bounded list of signed words.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Create, append,
// drop last, resize and count finish in the cycle they are taken; their one
// result shows in the next cycle. Remove walks the slot, reading and checking
// each word searched (S_FD_ISS, S_FD_CHK) and reading and writing each word
// moved up (S_MV_ISS, S_MV_WR). Reads produce each element with one pass
// over the slot or the whole bank (S_RD_ISS, S_RD_CHK per word) then S_EMIT,
// so n elements take n passes; the single read port of the word store and
// the single key comparator set this. Results come with result_valid for one
// cycle each and cannot be held off; a command's final result has last set.
// ----------------------------------------------------------------------------
module slotted_bounded_list_bank_unit
  import sblb_pkg::*;
#(
  parameter int NUM_SLOTS     = 8,
  parameter int SLOT_CAPACITY = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [CMD_W-1:0]           command,
  input  wire logic [SLOT_W-1:0]          slot,
  input  wire logic signed [DATA_W-1:0]   value,
  input  wire logic signed [AMOUNT_W-1:0] amount,
  output logic                            result_valid,
  output logic [STATUS_W-1:0]             status,
  output logic signed [DATA_W-1:0]        element,
  output logic [COUNT_W-1:0]              count,
  output logic                            last
);

  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OFW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int AW  = SIW + OFW;
  localparam int TW  = $clog2(NUM_SLOTS * SLOT_CAPACITY + 1);

  localparam logic [SIW-1:0] SLOT_LAST = SIW'(NUM_SLOTS - 1);
  localparam logic [OFW-1:0] OFS_LAST  = OFW'(SLOT_CAPACITY - 1);
  localparam logic [6:0]     CAP_LIM   = 7'(SLOT_CAPACITY);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NUM_SLOTS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_ISS = 3'd1;
  localparam logic [2:0] S_RD_CHK = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_FD_ISS = 3'd4;
  localparam logic [2:0] S_FD_CHK = 3'd5;
  localparam logic [2:0] S_MV_ISS = 3'd6;
  localparam logic [2:0] S_MV_WR  = 3'd7;

  logic [2:0] state;

  // Per-slot bookkeeping
  logic             present [NUM_SLOTS];
  logic [3:0]       cap     [NUM_SLOTS];
  logic [3:0]       fill    [NUM_SLOTS];

  // Command context
  logic [SIW-1:0]    sidx;
  logic [DATA_W-1:0] ref_value;
  logic              all_slots;
  logic              sorted;
  logic [TW-1:0]     total;
  logic [TW-1:0]     emitted;
  logic [OFW-1:0]    ofs;

  // Scan context
  logic [SIW-1:0]    scan_s;
  logic [OFW-1:0]    scan_o;
  logic              have_prev;
  logic              have_best;
  logic [DATA_W-1:0] prev_value;
  logic [AW-1:0]     prev_addr;
  logic [DATA_W-1:0] best_value;
  logic [AW-1:0]     best_addr;

  // Word store ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  key_cmp_t          cmp;

  // Decode of the command at the port
  logic              accept;
  logic [SLOT_W-1:0] slot_m1;
  logic [SIW-1:0]    acc_sidx;
  logic              bad_slot;
  logic [6:0]        amt_ext;
  logic [6:0]        new_cap;
  logic [TW-1:0]     bank_total;
  logic              scan_end;
  logic              in_range;

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign slot_m1  = slot - SLOT_W'(1);
  assign acc_sidx = slot_m1[SIW-1:0];
  assign bad_slot = (slot == '0) || (slot > SLOT_MAX);
  assign amt_ext  = {{2{amount[AMOUNT_W-1]}}, amount};
  assign new_cap  = {3'b000, cap[acc_sidx]} + amt_ext;

  // Sum the fills of all slots (absent slots hold zero fill)
  always_comb begin
    bank_total = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      bank_total = bank_total + TW'(fill[k]);
    end
  end

  assign scan_end = (scan_o == OFS_LAST) && (!all_slots || scan_s == SLOT_LAST);
  assign in_range = (all_slots || scan_s == sidx) && ({1'b0, scan_o} < 4'(fill[scan_s]));

  // Steer the word store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {scan_s, scan_o};
    mem_wdata = mem_rdata;
    case (state)
      S_FD_ISS: mem_raddr = {sidx, ofs};
      S_MV_ISS: mem_raddr = {sidx, ofs + OFW'(1)};
      default:  mem_raddr = {scan_s, scan_o};
    endcase
    if (state == S_IDLE && accept && command == CMD_APPEND && !bad_slot &&
        present[acc_sidx] && fill[acc_sidx] < cap[acc_sidx]) begin
      mem_we    = 1'b1;
      mem_waddr = {acc_sidx, fill[acc_sidx][OFW-1:0]};
      mem_wdata = value;
    end else if (state == S_MV_WR) begin
      mem_we    = 1'b1;
      mem_waddr = {sidx, ofs};
      mem_wdata = mem_rdata;
    end
  end

  sblb_store #(
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sblb_key_unit #(
    .AW (AW)
  ) u_key (
    .sorted     (sorted),
    .cand_value (mem_rdata),
    .cand_addr  ({scan_s, scan_o}),
    .prev_value (prev_value),
    .prev_addr  (prev_addr),
    .best_value (best_value),
    .best_addr  (best_addr),
    .ref_value  (ref_value),
    .cmp        (cmp)
  );

  // Control sequencer and slot bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        present[k] <= 1'b0;
        cap[k]     <= '0;
        fill[k]    <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      element      <= '0;
      count        <= '0;
      last         <= 1'b1;
      status       <= ST_OK;
      case (state)
        S_IDLE: begin
          if (accept) begin
            sidx      <= acc_sidx;
            ref_value <= value;
            ofs       <= '0;
            scan_o    <= '0;
            have_prev <= 1'b0;
            have_best <= 1'b0;
            emitted   <= '0;
            if (command inside {CMD_READ_ALL, CMD_READ_ALL_SORTED}) begin
              all_slots <= 1'b1;
              sorted    <= command == CMD_READ_ALL_SORTED;
              total     <= bank_total;
              scan_s    <= '0;
              if (bank_total == '0) begin
                result_valid <= 1'b1;
                status       <= ST_ALL_EMPTY;
              end else begin
                state <= S_RD_ISS;
              end
            end else if (command <= CMD_READ_ALL_SORTED) begin
              result_valid <= 1'b1;
              all_slots    <= 1'b0;
              sorted       <= command == CMD_READ_SORTED;
              total        <= TW'(fill[acc_sidx]);
              scan_s       <= acc_sidx;
              if (bad_slot) begin
                status <= ST_BAD_SLOT;
              end else if (command == CMD_CREATE) begin
                if (present[acc_sidx]) begin
                  status <= ST_EXISTS;
                end else if (amount < 5'sd1) begin
                  status <= ST_BAD_SIZE;
                end else if ($signed(amt_ext) > $signed(CAP_LIM)) begin
                  status <= ST_NO_MEMORY;
                end else begin
                  present[acc_sidx] <= 1'b1;
                  cap[acc_sidx]     <= amount[3:0];
                  fill[acc_sidx]    <= '0;
                end
              end else if (!present[acc_sidx]) begin
                status <= ST_NO_LIST;
              end else begin
                case (command)
                  CMD_APPEND: begin
                    if (fill[acc_sidx] >= cap[acc_sidx]) begin
                      status <= ST_FULL;
                    end else begin
                      fill[acc_sidx] <= fill[acc_sidx] + 4'd1;
                    end
                  end
                  CMD_DROP_LAST: begin
                    if (fill[acc_sidx] == '0) begin
                      status <= ST_EMPTY;
                    end else begin
                      fill[acc_sidx] <= fill[acc_sidx] - 4'd1;
                    end
                  end
                  CMD_RESIZE: begin
                    if ($signed(new_cap) < 7'sd1) begin
                      status <= ST_BAD_NEW_SIZE;
                    end else if ($signed(new_cap) > $signed(CAP_LIM)) begin
                      status <= ST_NO_MEMORY;
                    end else begin
                      cap[acc_sidx] <= new_cap[3:0];
                      if (fill[acc_sidx] > new_cap[3:0]) begin
                        fill[acc_sidx] <= new_cap[3:0];
                      end
                    end
                  end
                  CMD_COUNT: begin
                    if (fill[acc_sidx] == '0) begin
                      status <= ST_EMPTY;
                    end else begin
                      count <= fill[acc_sidx];
                    end
                  end
                  default: begin
                    // Remove and single-slot reads: walk the slot
                    if (fill[acc_sidx] == '0) begin
                      status <= ST_EMPTY;
                    end else begin
                      result_valid <= 1'b0;
                      state <= (command == CMD_REMOVE) ? S_FD_ISS : S_RD_ISS;
                    end
                  end
                endcase
              end
            end
          end
        end
        S_RD_ISS: begin
          state <= S_RD_CHK;
        end
        S_RD_CHK: begin
          // Keep the smallest key above the last one emitted
          if (in_range && (!have_prev || cmp.above_prev) &&
              (!have_best || cmp.below_best)) begin
            have_best  <= 1'b1;
            best_value <= mem_rdata;
            best_addr  <= {scan_s, scan_o};
          end
          if (scan_end) begin
            state <= S_EMIT;
          end else begin
            state <= S_RD_ISS;
            if (scan_o == OFS_LAST) begin
              scan_o <= '0;
              scan_s <= scan_s + SIW'(1);
            end else begin
              scan_o <= scan_o + OFW'(1);
            end
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          element      <= best_value;
          last         <= emitted == total - TW'(1);
          prev_value   <= best_value;
          prev_addr    <= best_addr;
          have_prev    <= 1'b1;
          have_best    <= 1'b0;
          emitted      <= emitted + TW'(1);
          scan_o       <= '0;
          scan_s       <= all_slots ? '0 : sidx;
          state        <= (emitted == total - TW'(1)) ? S_IDLE : S_RD_ISS;
        end
        S_FD_ISS: begin
          state <= S_FD_CHK;
        end
        S_FD_CHK: begin
          if (cmp.match) begin
            if (4'(ofs) + 4'd1 < fill[sidx]) begin
              state <= S_MV_ISS;
            end else begin
              fill[sidx]   <= fill[sidx] - 4'd1;
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end
          end else if (4'(ofs) + 4'd1 >= fill[sidx]) begin
            result_valid <= 1'b1;
            status       <= ST_NOT_FOUND;
            state        <= S_IDLE;
          end else begin
            ofs   <= ofs + OFW'(1);
            state <= S_FD_ISS;
          end
        end
        S_MV_ISS: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          // Close the gap one word at a time
          ofs <= ofs + OFW'(1);
          if (4'(ofs) + 4'd2 < fill[sidx]) begin
            state <= S_MV_ISS;
          end else begin
            fill[sidx]   <= fill[sidx] - 4'd1;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A stream that is not finished keeps the block busy
  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("stream element without last while idle");

  // The store is written only by an append or a compaction step
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_IDLE && accept) || state == S_MV_WR))
    else $error("unexpected store write");

  // Emission never runs past the element total
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emitted < total))
    else $error("more elements emitted than stored");

  // A result leaves the block idle or continues a read
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(state) == S_EMIT && !$past(rst)) |-> (result_valid && !last))
    else $error("read resumed without streaming an element");

  // Fill never exceeds capacity
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_fill_chk
    a_fill_cap: assert property (@(posedge clk) disable iff (rst)
      fill[g] <= cap[g])
      else $error("slot fill above capacity");
  end

endmodule : slotted_bounded_list_bank_unit
`default_nettype wire
